### rtl/vss_pkg.sv
// ----------------------------------------------------------------------------
// vss_pkg
// Shared types and codes for the value search stack: action and status
// codes, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package vss_pkg;

  localparam int DATA_W = 32;

  localparam logic [2:0] ACT_PUSH    = 3'd0;
  localparam logic [2:0] ACT_SEARCH  = 3'd1;
  localparam logic [2:0] ACT_MODIFY  = 3'd2;
  localparam logic [2:0] ACT_DELETE  = 3'd3;
  localparam logic [2:0] ACT_DISPLAY = 3'd4;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef enum logic [1:0] {
    WR_KEY,
    WR_REPL,
    WR_RDATA
  } wr_sel_t;

  typedef enum logic [1:0] {
    WA_COUNT,
    WA_TAG,
    WA_TAG_PREV
  } wr_at_t;

  typedef struct packed {
    logic       load;
    logic       ptr_top;
    logic       ptr_dec;
    logic       ptr_next;
    logic       ptr_inc;
    logic       wr_en;
    wr_sel_t    wr_sel;
    wr_at_t     wr_at;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       emit;
    logic [2:0] emit_status;
    logic       emit_show;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       empty;
    logic       full;
    logic       match;
    logic       tag_zero;
    logic       tag_top;
  } stat_t;

endpackage

### rtl/value_search_stack_core.sv
// ----------------------------------------------------------------------------
// value_search_stack_core
// Bounded LIFO store of signed 32-bit words with push, search, modify,
// delete of the topmost match and top-to-bottom display.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Results come out
// on status, data and last for one cycle each, marked by strobe, and cannot be
// held off. Push, and search, modify, delete or display on an empty store,
// answer from the dispatch state. Search and modify walk the memory from the
// top, one entry a cycle through its single read port, up to the first match
// or the bottom entry. Delete adds a shift of the entries above the match, one
// per cycle. Display gives one result per cycle. The next transaction can
// start on the cycle the last result is shown. Unused action codes give no
// result.
module value_search_stack_core #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         action,
  input  logic signed [31:0] value,
  input  logic signed [31:0] new_value,
  output logic               busy,
  output logic               strobe,
  output logic [2:0]         status,
  output logic signed [31:0] data,
  output logic               last
);

  vss_pkg::cmd_t  cmd;
  vss_pkg::stat_t stat;

  vss_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  vss_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .action   (action),
    .value    (value),
    .new_value(new_value),
    .cmd      (cmd),
    .stat     (stat),
    .strobe   (strobe),
    .status   (status),
    .data     (data),
    .last     (last)
  );

endmodule

### rtl/vss_ram.sv
// ----------------------------------------------------------------------------
// vss_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/vss_dp.sv
// ----------------------------------------------------------------------------
// vss_dp
// Datapath: entry memory, entry count, scan pointer, key and replacement
// registers, match compare and the result registers.
// ----------------------------------------------------------------------------
module vss_dp #(
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW  = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [2:0]                action,
  input  logic [vss_pkg::DATA_W-1:0] value,
  input  logic [vss_pkg::DATA_W-1:0] new_value,
  input  vss_pkg::cmd_t             cmd,
  output vss_pkg::stat_t            stat,
  output logic                      strobe,
  output logic [2:0]                status,
  output logic [vss_pkg::DATA_W-1:0] data,
  output logic                      last
);

  logic [2:0]                 op;
  logic [vss_pkg::DATA_W-1:0] key;
  logic [vss_pkg::DATA_W-1:0] repl;
  logic [CntW-1:0]            count;
  logic [AddrW-1:0]           ptr;
  logic [AddrW-1:0]           tag;
  logic [vss_pkg::DATA_W-1:0] rdata;
  logic                       wr_en;
  logic [AddrW-1:0]           wr_addr;
  logic [vss_pkg::DATA_W-1:0] wr_data;

  vss_ram #(
    .WIDTH(vss_pkg::DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(ptr),
    .rd_data(rdata)
  );

  assign wr_en = cmd.wr_en;

  always_comb begin
    unique case (cmd.wr_sel)
      vss_pkg::WR_KEY:   wr_data = key;
      vss_pkg::WR_REPL:  wr_data = repl;
      vss_pkg::WR_RDATA: wr_data = rdata;
      default:           wr_data = key;
    endcase
    unique case (cmd.wr_at)
      vss_pkg::WA_COUNT:    wr_addr = count[AddrW-1:0];
      vss_pkg::WA_TAG:      wr_addr = tag;
      vss_pkg::WA_TAG_PREV: wr_addr = tag - AddrW'(1);
      default:              wr_addr = tag;
    endcase
  end

  assign stat.action   = op;
  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CntW'(DEPTH));
  assign stat.match    = (rdata == key);
  assign stat.tag_zero = (tag == '0);
  assign stat.tag_top  = ((CntW'(tag) + CntW'(1)) == count);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= action;
      key  <= value;
      repl <= new_value;
    end
    tag <= ptr;
    priority if (cmd.ptr_top) begin
      ptr <= AddrW'(count - CntW'(1));
    end else if (cmd.ptr_next) begin
      ptr <= tag + AddrW'(1);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + AddrW'(1);
    end else if (cmd.ptr_dec && ptr != '0) begin
      ptr <= ptr - AddrW'(1);
    end else begin
      ptr <= ptr;
    end
    status <= cmd.emit_status;
    data   <= cmd.emit_show ? rdata : '0;
    last   <= cmd.emit_last;
    if (rst) begin
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
      if (cmd.cnt_inc) begin
        count <= count + CntW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

### rtl/vss_ctrl.sv
// ----------------------------------------------------------------------------
// vss_ctrl
// Controller: sequences push, scan, shift-down delete and display over the
// datapath, one transaction at a time.
// ----------------------------------------------------------------------------
module vss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  vss_pkg::stat_t stat,
  output vss_pkg::cmd_t  cmd,
  output logic           busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT_PRIME,
    S_SHIFT,
    S_SHOW
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.wr_sel      = vss_pkg::WR_KEY;
    cmd.wr_at       = vss_pkg::WA_COUNT;
    cmd.emit_status = vss_pkg::ST_DONE;
    cmd.emit_last   = 1'b1;
    state_next      = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.ptr_top = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_IDLE;
        if (stat.action == vss_pkg::ACT_PUSH) begin
          cmd.emit = 1'b1;
          if (stat.full) begin
            cmd.emit_status = vss_pkg::ST_FULL;
          end else begin
            cmd.wr_en   = 1'b1;
            cmd.cnt_inc = 1'b1;
          end
        end else if (stat.action == vss_pkg::ACT_SEARCH ||
                     stat.action == vss_pkg::ACT_MODIFY ||
                     stat.action == vss_pkg::ACT_DELETE ||
                     stat.action == vss_pkg::ACT_DISPLAY) begin
          if (stat.empty) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = vss_pkg::ST_EMPTY;
          end else begin
            cmd.ptr_dec = 1'b1;
            state_next  = (stat.action == vss_pkg::ACT_DISPLAY) ? S_SHOW : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.match) begin
          state_next = S_IDLE;
          if (stat.action == vss_pkg::ACT_SEARCH) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = vss_pkg::ST_FOUND;
          end else if (stat.action == vss_pkg::ACT_MODIFY) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = vss_pkg::WR_REPL;
            cmd.wr_at  = vss_pkg::WA_TAG;
            cmd.emit   = 1'b1;
          end else if (stat.tag_top) begin
            cmd.cnt_dec = 1'b1;
            cmd.emit    = 1'b1;
          end else begin
            cmd.ptr_next = 1'b1;
            state_next   = S_SHIFT_PRIME;
          end
        end else if (stat.tag_zero) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = vss_pkg::ST_NOT_FOUND;
          state_next      = S_IDLE;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      S_SHIFT_PRIME: begin
        cmd.ptr_inc = 1'b1;
        state_next  = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = vss_pkg::WR_RDATA;
        cmd.wr_at  = vss_pkg::WA_TAG_PREV;
        if (stat.tag_top) begin
          cmd.cnt_dec = 1'b1;
          cmd.emit    = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_SHOW: begin
        cmd.emit      = 1'b1;
        cmd.emit_show = 1'b1;
        cmd.emit_last = stat.tag_zero;
        if (stat.tag_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.ptr_dec = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
